// ===== rtl/core/ogc_pkg.sv =====
// Package for the OTP white-balance gain calibration core.
// Holds the item types, field widths, status and register codes.
// No dependencies.
package ogc_pkg;

   localparam int unsigned RATIO_W     = 10;
   localparam int unsigned SCALED_W    = 20;
   localparam int unsigned GAIN_W      = 30;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned SCALE       = 1000;
   localparam int unsigned UNITY       = 1024;
   localparam int unsigned RG_RESET    = 304;
   localparam int unsigned BG_RESET    = 300;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SKIP      = 2'd1,
      STATUS_BASE_ZERO = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TYPICAL_RG = 2'd0,
      CSR_TYPICAL_BG = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] rg_high_byte;
      logic [7:0] bg_high_byte;
      logic [7:0] packed_low_bits;
   } req_type;

   typedef struct packed {
      logic [GAIN_W-1:0] red_gain;
      logic [GAIN_W-1:0] green_gain;
      logic [GAIN_W-1:0] blue_gain;
      logic              red_write;
      logic              green_write;
      logic              blue_write;
      logic [1:0]        status;
   } rsp_type;

endpackage

// ===== rtl/core/ogc_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per item.
// Standalone; instantiated in rows by ogc_div_chain.
module ogc_div_cell #(
   parameter int unsigned NUM_W = 20,
   parameter int unsigned DIV_W = 10
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DIV_W-1:0] rem_i,
   input  logic [NUM_W-1:0] num_i,
   input  logic [DIV_W-1:0] div_i,
   output logic [DIV_W-1:0] rem_o,
   output logic [NUM_W-1:0] num_o,
   output logic [DIV_W-1:0] div_o
);

   logic [DIV_W:0]   rem_cat;
   logic [DIV_W:0]   diff;
   logic             ge;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] div_ff;

   // shift in the next numerator bit and try the subtraction
   always_comb begin
      rem_cat = {rem_i, num_i[NUM_W-1]};
      diff    = rem_cat - {1'b0, div_i};
      ge      = (rem_cat >= {1'b0, div_i});
      rem_in  = ge ? diff[DIV_W-1:0] : rem_cat[DIV_W-1:0];
      num_in  = {num_i[NUM_W-2:0], ge};
   end

   // advance the partial result to the next cell
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         div_ff <= div_i;
      end
   end

   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign div_o = div_ff;

endmodule

// ===== rtl/core/ogc_div_chain.sv =====
// Row of division cells, LANES dividers in step, one quotient bit per cell.
// Carries item valid and side data alongside. Uses ogc_div_cell.
module ogc_div_chain #(
   parameter int unsigned LANES  = 2,
   parameter int unsigned NUM_W  = 20,
   parameter int unsigned DIV_W  = 10,
   parameter int unsigned SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NUM_W-1:0] in_num,
   input  logic [LANES-1:0][DIV_W-1:0] in_div,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][NUM_W-1:0] out_quot,
   output logic [SIDE_W-1:0]           out_side
);

   logic [LANES-1:0][NUM_W:0][DIV_W-1:0] rem;
   logic [LANES-1:0][NUM_W:0][NUM_W-1:0] num;
   logic [LANES-1:0][NUM_W:0][DIV_W-1:0] div;
   logic [NUM_W-1:0]                     valid_ff;
   logic [NUM_W-1:0][SIDE_W-1:0]         side_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign rem[l][0] = '0;
      assign num[l][0] = in_num[l];
      assign div[l][0] = in_div[l];
      for (genvar k = 0; k < NUM_W; k++) begin : g_cell
         ogc_div_cell #(.NUM_W(NUM_W), .DIV_W(DIV_W)) u_cell (
            .clock (clock),
            .en    (en),
            .rem_i (rem[l][k]),
            .num_i (num[l][k]),
            .div_i (div[l][k]),
            .rem_o (rem[l][k+1]),
            .num_o (num[l][k+1]),
            .div_o (div[l][k+1])
         );
      end
      assign out_quot[l] = num[l][NUM_W];
   end

   // move item valid along the row
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NUM_W-2:0], in_valid};
      end
   end

   // move side data along the row
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= {side_ff[NUM_W-2:0], in_side};
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== rtl/core/otp_awb_gain_calibration_core.sv =====
// Top level of the OTP white-balance gain calibration core.
// Uses ogc_pkg and two rows of ogc_div_chain.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | ogc_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | ogc_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One item per cycle unless stalled; stages: an input register, 20 cells for the
// scaled ratios, a base register, 30 cells for the gains, an output register.
// The whole pipeline holds while a result is stalled at the output.
// Synchronous reset clears valids and sets the typical ratios to 304 and 300.
module otp_awb_gain_calibration_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ogc_pkg::req_type                     req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ogc_pkg::rsp_type                     rsp,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ogc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ogc_pkg::RATIO_W-1:0]          csr_data
);

   localparam int unsigned RW = ogc_pkg::RATIO_W;
   localparam int unsigned SW = ogc_pkg::SCALED_W;
   localparam int unsigned GW = ogc_pkg::GAIN_W;

   logic                     en;
   logic [RW-1:0]            typical_rg_ff, typical_bg_ff;
   logic [RW-1:0]            rg, bg;

   logic                     s0_valid_ff;
   logic [1:0][SW-1:0]       s0_num_ff;
   logic [1:0][RW-1:0]       s0_div_ff;
   logic                     s0_zero_ff;

   logic                     a_valid;
   logic [1:0][SW-1:0]       a_quot;
   logic                     a_zero;

   logic [SW-1:0]            n_r, n_b, base;
   ogc_pkg::status_type      s1_status_in;
   logic                     s1_valid_ff;
   logic [2:0][GW-1:0]       s1_num_ff;
   logic [2:0][RW-1:0]       s1_div_ff;
   logic [1:0]               s1_status_ff;

   logic                     b_valid;
   logic [2:0][GW-1:0]       b_quot;
   logic [1:0]               b_status;

   logic                     rsp_valid_ff;
   ogc_pkg::rsp_type         rsp_ff, rsp_in;

   // advance everything unless a result is held at the output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         typical_rg_ff <= RW'(ogc_pkg::RG_RESET);
         typical_bg_ff <= RW'(ogc_pkg::BG_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            ogc_pkg::CSR_TYPICAL_RG: typical_rg_ff <= csr_data;
            ogc_pkg::CSR_TYPICAL_BG: typical_bg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // rebuild the module ratios
   assign rg = {req.rg_high_byte, req.packed_low_bits[7:6]};
   assign bg = {req.bg_high_byte, req.packed_low_bits[5:4]};

   // input register: scale the typical ratios
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_num_ff[0] <= {{(SW-RW){1'b0}}, typical_rg_ff} * SW'(ogc_pkg::SCALE);
         s0_num_ff[1] <= {{(SW-RW){1'b0}}, typical_bg_ff} * SW'(ogc_pkg::SCALE);
         s0_div_ff[0] <= rg;
         s0_div_ff[1] <= bg;
         s0_zero_ff   <= (rg == '0) || (bg == '0);
      end
   end

   ogc_div_chain #(.LANES(2), .NUM_W(SW), .DIV_W(RW), .SIDE_W(1)) u_ratio_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_num    (s0_num_ff),
      .in_div    (s0_div_ff),
      .in_side   (s0_zero_ff),
      .out_valid (a_valid),
      .out_quot  (a_quot),
      .out_side  (a_zero)
   );

   // pick the base and classify the item
   always_comb begin
      n_r = a_quot[0];
      n_b = a_quot[1];
      if ((n_r < SW'(ogc_pkg::SCALE)) || (n_b < SW'(ogc_pkg::SCALE))) begin
         base = (n_r < n_b) ? n_r : n_b;
      end else begin
         base = SW'(ogc_pkg::SCALE);
      end
      if (a_zero) begin
         s1_status_in = ogc_pkg::STATUS_SKIP;
      end else if (base == '0) begin
         s1_status_in = ogc_pkg::STATUS_BASE_ZERO;
      end else begin
         s1_status_in = ogc_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= a_valid;
      end
   end

   // base register: base never exceeds the scale, so it fits a ratio width
   always_ff @(posedge clock) begin
      if (en) begin
         s1_num_ff[0] <= {n_r, {(GW-SW){1'b0}}};
         s1_num_ff[1] <= GW'(ogc_pkg::SCALE * ogc_pkg::UNITY);
         s1_num_ff[2] <= {n_b, {(GW-SW){1'b0}}};
         s1_div_ff[0] <= base[RW-1:0];
         s1_div_ff[1] <= base[RW-1:0];
         s1_div_ff[2] <= base[RW-1:0];
         s1_status_ff <= s1_status_in;
      end
   end

   ogc_div_chain #(.LANES(3), .NUM_W(GW), .DIV_W(RW), .SIDE_W(2)) u_gain_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_num_ff),
      .in_div    (s1_div_ff),
      .in_side   (s1_status_ff),
      .out_valid (b_valid),
      .out_quot  (b_quot),
      .out_side  (b_status)
   );

   // form the result, zeroed for skipped or failed items
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = b_status;
      if (b_status == ogc_pkg::STATUS_OK) begin
         rsp_in.red_gain    = b_quot[0];
         rsp_in.green_gain  = b_quot[1];
         rsp_in.blue_gain   = b_quot[2];
         rsp_in.red_write   = (b_quot[0] > GW'(ogc_pkg::UNITY));
         rsp_in.green_write = (b_quot[1] > GW'(ogc_pkg::UNITY));
         rsp_in.blue_write  = (b_quot[2] > GW'(ogc_pkg::UNITY));
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/ogc_checker.sv =====
// Port-level checks for the OTP white-balance gain calibration core.
// Uses ogc_pkg; bound to otp_awb_gain_calibration_core below.
module ogc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input ogc_pkg::rsp_type                rsp
);

   // hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result item changed");

   // stall input only while a result is held
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall without a held result");

   // zero gains on skipped or failed items
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ogc_pkg::STATUS_OK) |->
      (rsp.red_gain == '0) && (rsp.green_gain == '0) && (rsp.blue_gain == '0) &&
      !rsp.red_write && !rsp.green_write && !rsp.blue_write)
      else $error("nonzero gain on a failed item");

   // green gain is never below unity since the base never exceeds the scale
   a_green_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == ogc_pkg::STATUS_OK) |->
      (rsp.green_gain >= ogc_pkg::GAIN_W'(ogc_pkg::UNITY)))
      else $error("green gain below unity");

endmodule

bind otp_awb_gain_calibration_core ogc_checker u_ogc_checker (.*);

// ===== sim/testbench.sv =====
// Testbench for the OTP white-balance gain calibration core.
// Drives calibration items through a table of directed rows and random items,
// predicts each set of gains or takes one typed in by hand, and checks it field by field. Uses ogc_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ogc_pkg::*;

   localparam int LATENCY     = 53;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT = 400000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [RATIO_W-1:0]      csr_data;

   // Predictor's copy of the typical ratios
   logic [RATIO_W-1:0] model_rg;
   logic [RATIO_W-1:0] model_bg;

   rsp_type gain_queue[$];
   int      error_count;
   int      cycle_count;
   bit      quiet_phase;

   // Directed row: an item, and optionally a result typed in by hand
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type result;
   } row_type;

   otp_awb_gain_calibration_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Work out the gains for one item from the current typical ratios
   function automatic rsp_type calibrate_gains(req_type item);
      logic [63:0] rg;
      logic [63:0] bg;
      logic [63:0] scaled_r;
      logic [63:0] scaled_b;
      logic [63:0] base;
      logic [63:0] r_gain;
      logic [63:0] g_gain;
      logic [63:0] b_gain;
      rsp_type     result;
      result = '0;
      rg = {item.rg_high_byte, item.packed_low_bits[7:6]};
      bg = {item.bg_high_byte, item.packed_low_bits[5:4]};
      if (rg == 0 || bg == 0) begin
         result.status = STATUS_SKIP;
         return result;
      end
      scaled_r = (64'(model_rg) * SCALE) / rg;
      scaled_b = (64'(model_bg) * SCALE) / bg;
      if (scaled_r < SCALE || scaled_b < SCALE)
         base = (scaled_r < scaled_b) ? scaled_r : scaled_b;
      else
         base = SCALE;
      if (base == 0) begin
         result.status = STATUS_BASE_ZERO;
         return result;
      end
      r_gain = (UNITY * scaled_r) / base;
      g_gain = (UNITY * SCALE) / base;
      b_gain = (UNITY * scaled_b) / base;
      result.red_gain    = r_gain[GAIN_W-1:0];
      result.green_gain  = g_gain[GAIN_W-1:0];
      result.blue_gain   = b_gain[GAIN_W-1:0];
      result.red_write   = r_gain > UNITY;
      result.green_write = g_gain > UNITY;
      result.blue_write  = b_gain > UNITY;
      result.status      = STATUS_OK;
      return result;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, seen, wanted);
      error_count++;
   endtask

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gain_queue.size() == 0) begin
            $display("%0t: result with nothing expected", $realtime);
            error_count++;
         end else begin
            wanted = gain_queue.pop_front();
            if (rsp.red_gain !== wanted.red_gain)
               report_mismatch("red_gain", rsp.red_gain, wanted.red_gain);
            if (rsp.green_gain !== wanted.green_gain)
               report_mismatch("green_gain", rsp.green_gain, wanted.green_gain);
            if (rsp.blue_gain !== wanted.blue_gain)
               report_mismatch("blue_gain", rsp.blue_gain, wanted.blue_gain);
            if (rsp.red_write !== wanted.red_write)
               report_mismatch("red_write", rsp.red_write, wanted.red_write);
            if (rsp.green_write !== wanted.green_write)
               report_mismatch("green_write", rsp.green_write, wanted.green_write);
            if (rsp.blue_write !== wanted.blue_write)
               report_mismatch("blue_write", rsp.blue_write, wanted.blue_write);
            if (rsp.status !== wanted.status)
               report_mismatch("status", rsp.status, wanted.status);
         end
      end
   end

   // Stall the result side in bursts, except in the quiet phase
   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_stall = 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Guard against a hang
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Send one item, holding it until accepted, and queue its prediction
   task automatic send_item(req_type item, bit typed, rsp_type result);
      int burst;
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         burst = $urandom_range(1, 15);
         req_valid = 1'b0;
         repeat (burst) @(negedge clock);
      end
      req_valid = 1'b1;
      req       = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gain_queue.push_back(typed ? result : calibrate_gains(item));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Write one register once the pipeline has drained
   task automatic write_register(csr_index_type index, logic [RATIO_W-1:0] value);
      while (gain_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_TYPICAL_RG) model_rg = value;
      else if (index == CSR_TYPICAL_BG) model_bg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_type random_item();
      req_type item;
      item.rg_high_byte    = 8'($urandom);
      item.bg_high_byte    = 8'($urandom);
      item.packed_low_bits = 8'($urandom);
      // Bias towards small ratios and zero ratios now and then
      case ($urandom_range(0, 9))
         0: item.rg_high_byte = 8'($urandom_range(0, 3));
         1: item.bg_high_byte = 8'($urandom_range(0, 3));
         2: item.rg_high_byte = 8'($urandom_range(40, 120));
         default: ;
      endcase
      return item;
   endfunction

   initial begin
      row_type   rows[$];
      row_type   row;
      rsp_type   none;
      logic [RATIO_W-1:0] rg_settings[5];
      logic [RATIO_W-1:0] bg_settings[5];
      int        chunk;
      none        = '0;
      error_count = 0;
      quiet_phase = 1'b0;
      model_rg    = RATIO_W'(RG_RESET);
      model_bg    = RATIO_W'(BG_RESET);
      reset       = 1'b1;
      req_valid   = 1'b0;
      req         = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_TYPICAL_RG;
      csr_data    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows: zero ratios, extremes and typical values
      row = '{item: '{8'h00, 8'h00, 8'h00}, typed: 1, result: none};
      row.result.status = STATUS_SKIP;
      rows.push_back(row);
      row.item = '{8'h00, 8'hFF, 8'h3F};
      rows.push_back(row);
      row.item = '{8'hFF, 8'h00, 8'hCF};
      rows.push_back(row);
      // Module ratio equal to typical ratio: unity gains, nothing written
      row = '{item: '{8'd76, 8'd75, 8'h00}, typed: 1, result: none};
      row.result.red_gain   = 30'd1024;
      row.result.green_gain = 30'd1024;
      row.result.blue_gain  = 30'd1024;
      row.result.status     = STATUS_OK;
      rows.push_back(row);
      row.typed = 0;
      row.item = '{8'h00, 8'h00, 8'h40};
      rows.push_back(row);
      row.item = '{8'h00, 8'h00, 8'h50};
      rows.push_back(row);
      row.item = '{8'hFF, 8'hFF, 8'hFF};
      rows.push_back(row);
      row.item = '{8'hFF, 8'h01, 8'hF0};
      rows.push_back(row);
      row.item = '{8'h01, 8'hFF, 8'h0F};
      rows.push_back(row);
      row.item = '{8'd75, 8'd72, 8'hB5};
      rows.push_back(row);
      row.item = '{8'd157, 8'd137, 8'h00};
      rows.push_back(row);
      row.item = '{8'hAA, 8'h55, 8'hAA};
      rows.push_back(row);
      row.item = '{8'h55, 8'hAA, 8'h55};
      rows.push_back(row);
      foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);

      // Walk through register settings, extremes included, with random items
      rg_settings = '{10'd1, 10'd1023, 10'd0, 10'd512, 10'd291};
      bg_settings = '{10'd1023, 10'd1, 10'd628, 10'd0, 10'd550};
      chunk = RANDOM_ITEMS / 6;
      for (int s = 0; s <= 5; s++) begin
         if (s == 5) quiet_phase = 1'b1;
         for (int i = 0; i < chunk; i++) send_item(random_item(), 0, none);
         if (s < 5) begin
            write_register(CSR_TYPICAL_RG, rg_settings[s]);
            write_register(CSR_TYPICAL_BG, bg_settings[s]);
            // Directed zero-base row under a zero register
            if (rg_settings[s] == 0 || bg_settings[s] == 0) begin
               none.status = STATUS_BASE_ZERO;
               send_item('{8'h10, 8'h10, 8'h00}, 1, none);
               none = '0;
            end
         end
      end

      // Drain and finish
      while (gain_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      if (error_count == 0 && gain_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
